// ===== hw/rtl/fpfm_pkg.sv =====
// Package for the FIFO page frame manager.
// Holds sizes, field widths and result status codes; no dependencies.
package fpfm_pkg;
  localparam int PROCESSES  = 16;
  localparam int PAGES      = 32;
  localparam int FRAMES     = 256;
  localparam int PAGE_BYTES = 1024;

  localparam int PROC_W  = 4;
  localparam int PAGE_W  = 5;
  localparam int FRAME_W = 8;
  localparam int ADDR_W  = 15;
  localparam int SEQ_W   = 32;
  localparam int PTE_W   = FRAME_W + 2;
  localparam int PT_AW   = PROC_W + PAGE_W;
  localparam int OFF_W   = $clog2(PAGE_BYTES);

  typedef enum logic [2:0] {
    ST_HIT        = 3'd0,
    ST_FAULT_FREE = 3'd1,
    ST_FAULT_CLN  = 3'd2,
    ST_FAULT_DRT  = 3'd3,
    ST_TERM       = 3'd4,
    ST_TERM_IGN   = 3'd5
  } status_t;

  typedef struct packed {
    logic [PROC_W-1:0] owner;
    logic [PAGE_W-1:0] page;
  } frame_tag_t;
endpackage

// ===== hw/rtl/fifo_page_frame_manager_top.sv =====
// FIFO page frame manager: page tables, frame table and FIFO eviction.
// Depends on fpfm_pkg.
//
//  channel  ports                                         handshake
//  input    in_action in_process_id in_address in_is_write start & !busy
//  result   out_status out_frame out_page out_victim_*    out_valid, one cycle
//           out_frames_freed
//
// An ignored terminate is answered straight from idle, a hit after the page table
// lookup. A miss, with or without an eviction, and a terminate scan the frame
// table memory one entry a cycle.
// After reset a clearing pass walks the page table memory, and busy stays high
// meanwhile. The receiver cannot stall; each result is shown for one cycle with
// out_valid.
module fifo_page_frame_manager_top
  import fpfm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic [PROC_W-1:0]  in_process_id,
  input  logic [ADDR_W-1:0]  in_address,
  input  logic               in_is_write,
  output logic               out_valid,
  output logic [2:0]         out_status,
  output logic [FRAME_W-1:0] out_frame,
  output logic [PAGE_W-1:0]  out_page,
  output logic [PROC_W-1:0]  out_victim_process,
  output logic [PAGE_W-1:0]  out_victim_page,
  output logic [8:0]         out_frames_freed
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PLOOK, S_MSCAN, S_MREAD, S_MVIC, S_MAP, S_TSCAN
  } state_t;

  state_t               state_r;
  logic [8:0]           cnt_r;
  logic [PROC_W-1:0]    proc_r;
  logic [PAGE_W-1:0]    page_r;
  logic                 wr_r;
  logic [PROCESSES-1:0] active_r;
  logic [FRAMES-1:0]    occ_r;
  logic [SEQ_W-1:0]     load_seq_r;
  logic                 free_found_r;
  logic [FRAME_W-1:0]   free_idx_r;
  logic [SEQ_W-1:0]     min_seq_r;
  logic [FRAME_W-1:0]   min_idx_r;
  logic [FRAME_W-1:0]   chosen_r;
  logic [8:0]           freed_r;

  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic [FRAME_W-1:0]   out_frame_r;
  logic [PAGE_W-1:0]    out_page_r;
  logic [PROC_W-1:0]    out_vproc_r;
  logic [PAGE_W-1:0]    out_vpage_r;
  logic [8:0]           out_freed_r;

  // Memories with registered read data.
  logic [PTE_W-1:0]   pt_mem [PROCESSES*PAGES];
  logic [SEQ_W-1:0]   seq_mem [FRAMES];
  frame_tag_t         tag_mem [FRAMES];
  logic               drt_mem [FRAMES];
  logic [PTE_W-1:0]   pt_rd_r;
  logic [SEQ_W-1:0]   seq_rd_r;
  frame_tag_t         tag_rd_r;
  logic               drt_rd_r;

  logic               pt_we;
  logic [PT_AW-1:0]   pt_wa;
  logic [PTE_W-1:0]   pt_wd;
  logic               drt_we;
  logic [FRAME_W-1:0] drt_wa;
  logic               drt_wd;
  logic [FRAME_W-1:0] fr_ra;

  logic               accept;
  logic [PAGE_W-1:0]  in_page;
  logic [FRAME_W-1:0] ev_idx;
  logic               ev_occ;
  logic               min_take;
  logic [FRAME_W-1:0] min_idx_fin;

  assign accept  = start && (state_r == S_IDLE);
  assign in_page = in_address[OFF_W +: PAGE_W];
  assign ev_idx  = FRAME_W'(cnt_r - 9'd1);
  assign ev_occ  = occ_r[ev_idx];
  assign min_take = (ev_idx == '0) || (seq_rd_r < min_seq_r);
  assign min_idx_fin = min_take ? ev_idx : min_idx_r;
  assign fr_ra = (state_r == S_MREAD) ? chosen_r : cnt_r[FRAME_W-1:0];

  always_comb begin
    pt_we  = 1'b0;
    pt_wa  = {proc_r, page_r};
    pt_wd  = '0;
    drt_we = 1'b0;
    drt_wa = chosen_r;
    drt_wd = wr_r;
    unique case (state_r)
      S_CLEAR: begin
        pt_we = 1'b1;
        pt_wa = cnt_r[PT_AW-1:0];
      end
      S_PLOOK: begin
        if (pt_rd_r[PTE_W-1] && wr_r) begin
          pt_we  = 1'b1;
          pt_wd  = {2'b11, pt_rd_r[FRAME_W-1:0]};
          drt_we = 1'b1;
          drt_wa = pt_rd_r[FRAME_W-1:0];
          drt_wd = 1'b1;
        end
      end
      S_MVIC: begin
        pt_we = 1'b1;
        pt_wa = {tag_rd_r.owner, tag_rd_r.page};
      end
      S_MAP: begin
        pt_we  = 1'b1;
        pt_wd  = {1'b1, wr_r, chosen_r};
        drt_we = 1'b1;
      end
      S_TSCAN: begin
        if (cnt_r < 9'(PAGES)) begin
          pt_we = 1'b1;
          pt_wa = {proc_r, cnt_r[PAGE_W-1:0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_wa] <= pt_wd;
    pt_rd_r <= pt_mem[{in_process_id, in_page}];
    if (drt_we) drt_mem[drt_wa] <= drt_wd;
    drt_rd_r <= drt_mem[fr_ra];
    if (state_r == S_MAP) begin
      seq_mem[chosen_r] <= load_seq_r;
      tag_mem[chosen_r] <= '{owner: proc_r, page: page_r};
    end
    seq_rd_r <= seq_mem[fr_ra];
    tag_rd_r <= tag_mem[fr_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      active_r    <= '0;
      occ_r       <= '0;
      load_seq_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          cnt_r <= cnt_r + 9'd1;
          if (cnt_r == 9'(PROCESSES*PAGES-1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            proc_r       <= in_process_id;
            page_r       <= in_page;
            wr_r         <= in_is_write;
            cnt_r        <= '0;
            free_found_r <= 1'b0;
            freed_r      <= '0;
            if (in_action) begin
              if (active_r[in_process_id]) begin
                state_r <= S_TSCAN;
              end else begin
                out_valid_r  <= 1'b1;
                out_status_r <= ST_TERM_IGN;
                out_frame_r  <= '0;
                out_page_r   <= '0;
                out_vproc_r  <= '0;
                out_vpage_r  <= '0;
                out_freed_r  <= '0;
              end
            end else begin
              active_r[in_process_id] <= 1'b1;
              state_r <= S_PLOOK;
            end
          end
        end
        S_PLOOK: begin
          if (pt_rd_r[PTE_W-1]) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_HIT;
            out_frame_r  <= pt_rd_r[FRAME_W-1:0];
            out_page_r   <= page_r;
            out_vproc_r  <= '0;
            out_vpage_r  <= '0;
            out_freed_r  <= '0;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_MSCAN;
          end
        end
        S_MSCAN: begin
          cnt_r <= cnt_r + 9'd1;
          if (cnt_r != '0) begin
            if (!free_found_r && !ev_occ) begin
              free_found_r <= 1'b1;
              free_idx_r   <= ev_idx;
            end
            if (min_take) begin
              min_seq_r <= seq_rd_r;
              min_idx_r <= ev_idx;
            end
            if (cnt_r == 9'(FRAMES)) begin
              out_vproc_r <= '0;
              out_vpage_r <= '0;
              if (free_found_r || !ev_occ) begin
                chosen_r     <= free_found_r ? free_idx_r : ev_idx;
                out_status_r <= ST_FAULT_FREE;
                state_r      <= S_MAP;
              end else begin
                chosen_r <= min_idx_fin;
                state_r  <= S_MREAD;
              end
            end
          end
        end
        S_MREAD: state_r <= S_MVIC;
        S_MVIC: begin
          out_status_r <= drt_rd_r ? ST_FAULT_DRT : ST_FAULT_CLN;
          out_vproc_r  <= tag_rd_r.owner;
          out_vpage_r  <= tag_rd_r.page;
          state_r      <= S_MAP;
        end
        S_MAP: begin
          occ_r[chosen_r] <= 1'b1;
          load_seq_r      <= load_seq_r + 32'd1;
          out_valid_r     <= 1'b1;
          out_frame_r     <= chosen_r;
          out_page_r      <= page_r;
          out_freed_r     <= '0;
          state_r         <= S_IDLE;
        end
        S_TSCAN: begin
          logic hit_own;
          hit_own = (cnt_r != '0) && ev_occ && (tag_rd_r.owner == proc_r);
          cnt_r <= cnt_r + 9'd1;
          if (hit_own) begin
            occ_r[ev_idx] <= 1'b0;
            freed_r       <= freed_r + 9'd1;
          end
          if (cnt_r == 9'(FRAMES)) begin
            active_r[proc_r] <= 1'b0;
            out_valid_r      <= 1'b1;
            out_status_r     <= ST_TERM;
            out_frame_r      <= '0;
            out_page_r       <= '0;
            out_vproc_r      <= '0;
            out_vpage_r      <= '0;
            out_freed_r      <= freed_r + 9'(hit_own);
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_frame          = out_frame_r;
  assign out_page           = out_page_r;
  assign out_victim_process = out_vproc_r;
  assign out_victim_page    = out_vpage_r;
  assign out_frames_freed   = out_freed_r;

  // A result only ever leaves with the block returning to idle.
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 3'd6 && out_status != 3'd7))
    else $error("bad status code");

  // A hit never reports a victim.
  a_hit_novictim: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_HIT) |-> (out_victim_process == '0 &&
     out_victim_page == '0 && out_frames_freed == '0))
    else $error("hit with victim data");

  // A mapping always bumps the load sequence by one.
  a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAP) |=> (load_seq_r == $past(load_seq_r) + 32'd1))
    else $error("load sequence step");
endmodule
